// File: hw/rtl/ecdf_pkg.sv
package ecdf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int VALUE_BITS  = 32;
    localparam int PROB_BITS   = 17;

    localparam logic [PROB_BITS-1:0] PROB_ONE  = PROB_BITS'(65536);
    localparam logic [PROB_BITS-1:0] PROB_ZERO = '0;
    localparam logic [CNT_BITS-1:0]  CNT_FULL  = CNT_BITS'(TABLE_DEPTH);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic                         value_missing;
        logic [PROB_BITS-1:0]         entry_probability;
    } in_item_t;

    typedef struct packed {
        logic [PROB_BITS-1:0] probability;
        logic                 result_missing;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic do_load;
        logic do_clear;
        logic start_search;
        logic set_missing;
        logic step;
        logic finish;
    } ecdf_cmd_t;

    typedef struct packed {
        logic table_empty;
        logic search_last;
        logic out_free;
    } ecdf_status_t;

endpackage

// File: hw/rtl/ecdf_ctrl.sv
module ecdf_ctrl
    import ecdf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   operation,
    input  logic         value_missing,
    input  ecdf_status_t status,
    output logic         in_ready,
    output ecdf_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && operation == OP_QUERY)
                begin
                    if (value_missing || status.table_empty)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (status.search_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (operation)
                        OP_LOAD:
                        begin
                            cmd.do_load = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            cmd.do_clear = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            if (value_missing || status.table_empty)
                            begin
                                cmd.set_missing = 1'b1;
                            end
                            else
                            begin
                                cmd.start_search = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/ecdf_dp.sv
module ecdf_dp
    import ecdf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  in_item_t     in_data,
    input  ecdf_cmd_t    cmd,
    input  logic         out_ready,
    output ecdf_status_t status,
    output logic         out_valid,
    output out_item_t    out_data
);

    logic signed [VALUE_BITS-1:0] value_mem [TABLE_DEPTH];
    logic [PROB_BITS-1:0]         prob_mem  [TABLE_DEPTH];

    logic [CNT_BITS-1:0]          count_reg;
    logic                         closed_reg;
    logic signed [VALUE_BITS-1:0] key_reg;
    logic [CNT_BITS-1:0]          first_reg;
    logic [CNT_BITS-1:0]          len_reg;
    logic                         miss_reg;
    logic signed [VALUE_BITS-1:0] val_rdata_reg;
    logic [PROB_BITS-1:0]         prob_rdata_reg;
    logic                         out_valid_reg;
    out_item_t                    out_data_reg;

    logic [CNT_BITS-1:0]  half;
    logic [CNT_BITS-1:0]  mid;
    logic                 probe_lt;
    logic [CNT_BITS-1:0]  first_next;
    logic [CNT_BITS-1:0]  len_next;
    logic [CNT_BITS-1:0]  step_addr;
    logic [CNT_BITS-1:0]  prob_addr;
    logic [ADDR_BITS-1:0] val_rd_addr;
    logic                 val_rd_en;
    logic                 prob_rd_en;
    logic                 wr_en;
    logic [PROB_BITS-1:0] wr_prob;

    // one probe per cycle: the next address comes straight from this compare
    always_comb
    begin
        half     = len_reg >> 1;
        mid      = first_reg + half;
        probe_lt = val_rdata_reg < key_reg;
        if (probe_lt)
        begin
            first_next = mid + CNT_BITS'(1);
            len_next   = len_reg - half - CNT_BITS'(1);
        end
        else
        begin
            first_next = first_reg;
            len_next   = half;
        end
        step_addr = first_next + (len_next >> 1);
        prob_addr = first_next - CNT_BITS'(1);
    end

    always_comb
    begin
        val_rd_en   = cmd.start_search || (cmd.step && len_next != '0);
        prob_rd_en  = cmd.step && len_next == '0;
        if (cmd.start_search)
        begin
            val_rd_addr = ADDR_BITS'(count_reg >> 1);
        end
        else
        begin
            val_rd_addr = step_addr[ADDR_BITS-1:0];
        end
        wr_en   = cmd.do_load && !closed_reg && !in_data.value_missing
                  && count_reg < CNT_FULL;
        wr_prob = (in_data.entry_probability > PROB_ONE) ? PROB_ONE
                                                         : in_data.entry_probability;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[count_reg[ADDR_BITS-1:0]] <= in_data.sample_value;
            prob_mem[count_reg[ADDR_BITS-1:0]]  <= wr_prob;
        end
        if (val_rd_en)
        begin
            val_rdata_reg <= value_mem[val_rd_addr];
        end
        if (prob_rd_en)
        begin
            prob_rdata_reg <= prob_mem[prob_addr[ADDR_BITS-1:0]];
        end
        if (cmd.start_search || cmd.set_missing)
        begin
            key_reg <= in_data.sample_value;
        end
        if (cmd.finish)
        begin
            if (miss_reg)
            begin
                out_data_reg.probability    <= PROB_ZERO;
                out_data_reg.result_missing <= 1'b1;
            end
            else
            begin
                out_data_reg.probability    <= (first_reg == '0) ? PROB_ZERO
                                                                 : prob_rdata_reg;
                out_data_reg.result_missing <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            first_reg     <= '0;
            len_reg       <= '0;
            miss_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                count_reg  <= '0;
                closed_reg <= 1'b0;
            end
            else if (cmd.do_load && !closed_reg && in_data.value_missing)
            begin
                closed_reg <= 1'b1;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end

            if (cmd.start_search)
            begin
                first_reg <= '0;
                len_reg   <= count_reg;
                miss_reg  <= 1'b0;
            end
            else if (cmd.set_missing)
            begin
                miss_reg <= 1'b1;
            end
            else if (cmd.step)
            begin
                first_reg <= first_next;
                len_reg   <= len_next;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.table_empty = count_reg == '0;
        status.search_last = len_next == '0;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/ecdf_left_limit_lookup.sv
// empirical cdf lookup, left limit: P(X < z) from a table of up to 1024 sorted signed
// values with Q1.16 cumulative probabilities. loads, clears and ignored items are taken
// without leaving the idle state. a query over n valid entries makes p probes of a
// lower-bound search, p being floor(log2(n)) or floor(log2(n)) + 1 depending on the path
// the search takes: each probe is one read of the value memory, and the last step also
// reads the probability memory. a missing query or an empty table skips the search and
// answers with result_missing set. a query also waits while the previous result is still
// unaccepted in the output register, taking no item meanwhile; loads and clears need no free output.
module ecdf_left_limit_lookup
    import ecdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    ecdf_cmd_t    cmd;
    ecdf_status_t status;

    ecdf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .operation     (in_data.operation),
        .value_missing (in_data.value_missing),
        .status        (status),
        .in_ready      (in_ready),
        .cmd           (cmd)
    );

    ecdf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: dv/tb_top.sv
module tb_top
    import ecdf_pkg::*;
();

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // predictor state
    logic signed [VALUE_BITS-1:0] table_values [TABLE_DEPTH];
    logic [PROB_BITS-1:0]         table_probs [TABLE_DEPTH];
    int                           entry_count = 0;
    bit                           table_sealed = 1'b0;

    out_item_t expected_lookups[$];
    stim_row_t directed[$];
    longint    loaded_values[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request = 1'b0;
    int  holds_done = 0;
    int  error_count = 0;
    int  results_checked = 0;
    int  effective_items = 0;
    int  items_sent = 0;
    int  overflow_loads = 0;
    int  idle_cycles = 0;

    ecdf_left_limit_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic in_item_t make_item(input logic [1:0] op,
                                           input logic [VALUE_BITS-1:0] value,
                                           input bit missing,
                                           input logic [PROB_BITS-1:0] prob);
        in_item_t it;
        it.operation         = op;
        it.sample_value      = value;
        it.value_missing     = missing;
        it.entry_probability = prob;
        return it;
    endfunction

    function automatic stim_row_t row(input logic [1:0] op, input logic [VALUE_BITS-1:0] value,
                                      input bit missing, input logic [PROB_BITS-1:0] prob,
                                      input bit typed, input logic [PROB_BITS-1:0] exp_prob,
                                      input bit exp_missing);
        stim_row_t r;
        r.item                  = make_item(op, value, missing, prob);
        r.typed                 = typed;
        r.result.probability    = exp_prob;
        r.result.result_missing = exp_missing;
        return r;
    endfunction

    function automatic logic [VALUE_BITS-1:0] sat32(input longint x);
        if (x > longint'($signed(VAL_MAX)))
            return VAL_MAX;
        if (x < longint'($signed(VAL_MIN)))
            return VAL_MIN;
        return x[VALUE_BITS-1:0];
    endfunction

    // left-limit cdf: probability of the last entry strictly below z
    function automatic bit predict_cdf_lookup(input in_item_t it, output out_item_t res,
                                              output bit counted);
        logic signed [VALUE_BITS-1:0] z;
        int first;
        int len;
        int half;
        int mid;
        res = '0;
        counted = 1'b0;
        z = it.sample_value;
        case (it.operation)
            OP_LOAD:
            begin
                if (table_sealed)
                    return 1'b0;
                counted = 1'b1;
                if (it.value_missing)
                begin
                    table_sealed = 1'b1;
                    return 1'b0;
                end
                if (entry_count >= TABLE_DEPTH)
                begin
                    counted = 1'b0;
                    overflow_loads++;
                    return 1'b0;
                end
                table_values[entry_count] = z;
                table_probs[entry_count] = (it.entry_probability > PROB_ONE) ?
                                           PROB_ONE : it.entry_probability;
                entry_count++;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                counted = 1'b1;
                entry_count = 0;
                table_sealed = 1'b0;
                return 1'b0;
            end
            OP_QUERY:
            begin
                counted = 1'b1;
                if (it.value_missing || entry_count == 0)
                begin
                    res.probability = PROB_ZERO;
                    res.result_missing = 1'b1;
                    return 1'b1;
                end
                first = 0;
                len = entry_count;
                while (len > 0)
                begin
                    half = len >> 1;
                    mid = first + half;
                    if (table_values[mid] < z)
                    begin
                        first = mid + 1;
                        len = len - half - 1;
                    end
                    else
                        len = half;
                end
                res.probability = (first > 0) ? table_probs[first-1] : PROB_ZERO;
                res.result_missing = 1'b0;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        out_item_t res;
        bit counted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (predict_cdf_lookup(it, res, counted))
            expected_lookups.push_back(typed ? typed_res : res);
        if (counted)
            effective_items++;
    endtask

    task automatic send(input in_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    function automatic logic [PROB_BITS-1:0] rand_prob();
        return PROB_BITS'($urandom_range(131071));
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_query();
        int sel;
        int off;
        sel = $urandom_range(9);
        off = $urandom_range(2);
        if (loaded_values.size() != 0 && sel < 6)
            return sat32(loaded_values[$urandom_range(loaded_values.size() - 1)] + off - 1);
        if (sel == 7)
            return VAL_MAX;
        if (sel == 8)
            return VAL_MIN;
        return $urandom;
    endfunction

    task automatic send_queries(input int count);
        repeat (count)
            send(make_item(OP_QUERY, pick_query(), $urandom_range(19) == 0, rand_prob()));
    endtask

    task automatic clear_table();
        loaded_values.delete();
        send(make_item(OP_CLEAR, $urandom, $urandom_range(1), rand_prob()));
    endtask

    task automatic run_sorted_session(input int max_len);
        longint      v;
        int unsigned spread;
        int          n;
        int          cum;
        n = $urandom_range(1, max_len);
        case ($urandom_range(3))
            0: spread = 3;
            1: spread = 1000;
            2: spread = 1 << 20;
            default: spread = 32'hffff_ffff / n;
        endcase
        if (spread > (1 << 20))
            v = longint'($signed(VAL_MIN)) + $urandom_range(1000);
        else
            v = longint'($signed($urandom));
        cum = 0;
        clear_table();
        for (int i = 0; i < n; i++)
        begin
            cum += $urandom_range(4000);
            send(make_item(OP_LOAD, sat32(v), 1'b0, (cum > 131071) ? 131071 : cum));
            loaded_values.push_back(v);
            v = longint'($signed(sat32(v + $urandom_range(0, spread))));
        end
        // sometimes seal the table and try a few more loads
        if ($urandom_range(9) < 4)
        begin
            send(make_item(OP_LOAD, $urandom, 1'b1, rand_prob()));
            repeat ($urandom_range(2))
                send(make_item(OP_LOAD, $urandom, 1'b0, rand_prob()));
        end
        send_queries($urandom_range(2, 12));
    endtask

    task automatic run_broken_session();
        logic [VALUE_BITS-1:0] v;
        clear_table();
        repeat ($urandom_range(1, 20))
        begin
            v = $urandom;
            send(make_item(OP_LOAD, v, 1'b0, rand_prob()));
            loaded_values.push_back(longint'($signed(v)));
        end
        send_queries($urandom_range(2, 10));
    endtask

    task automatic run_noise(input int count);
        repeat (count)
            send(make_item($urandom_range(3), $urandom, $urandom_range(1), rand_prob()));
    endtask

    // load past capacity and query, then seal the full table and query again
    task automatic fill_to_capacity();
        longint v;
        int     p;
        clear_table();
        v = longint'($signed(VAL_MIN)) + $urandom_range(1000);
        for (int i = 0; i < TABLE_DEPTH + 4; i++)
        begin
            p = i * 64 + $urandom_range(200);
            send(make_item(OP_LOAD, sat32(v), 1'b0, p));
            if (i < TABLE_DEPTH)
                loaded_values.push_back(v);
            v = longint'($signed(sat32(v + $urandom_range(4000000))));
        end
        send_queries(20);
        send(make_item(OP_LOAD, $urandom, 1'b1, rand_prob()));
        send_queries(5);
    endtask

    // output held off while queries keep coming, so the block backs up
    task automatic stall_output();
        clear_table();
        for (int i = 0; i < 4; i++)
        begin
            send(make_item(OP_LOAD, i * 100, 1'b0, (i + 1) * 16384));
            loaded_values.push_back(i * 100);
        end
        hold_request = 1'b1;
        send_queries(40);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lookups.size() == 0)
            begin
                $display("%0t: unexpected result probability %0d missing %0b",
                         $time, out_data.probability, out_data.result_missing);
                error_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                results_checked++;
                if (want.probability !== out_data.probability)
                begin
                    $display("%0t: probability mismatch expected %0d actual %0d",
                             $time, want.probability, out_data.probability);
                    error_count++;
                end
                if (want.result_missing !== out_data.result_missing)
                begin
                    $display("%0t: result_missing mismatch expected %0b actual %0b",
                             $time, want.result_missing, out_data.result_missing);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int target;
        int pick;

        // typed results: empty table, extremes, clamping, sealing, unknown op
        directed.push_back(row(OP_QUERY,   0,       1'b0, 0,      1, PROB_ZERO, 1));
        directed.push_back(row(OP_LOAD,    -5,      1'b0, 100,    0, 0,         0));
        directed.push_back(row(OP_LOAD,    10,      1'b0, 131071, 0, 0,         0));
        directed.push_back(row(OP_LOAD,    10,      1'b0, 70000,  0, 0,         0));
        directed.push_back(row(OP_QUERY,   -5,      1'b0, 0,      1, PROB_ZERO, 0));
        directed.push_back(row(OP_QUERY,   -4,      1'b0, 0,      1, 100,       0));
        directed.push_back(row(OP_QUERY,   10,      1'b0, 0,      1, 100,       0));
        directed.push_back(row(OP_QUERY,   11,      1'b0, 0,      1, PROB_ONE,  0));
        directed.push_back(row(OP_QUERY,   VAL_MAX, 1'b0, 0,      1, PROB_ONE,  0));
        directed.push_back(row(OP_QUERY,   VAL_MIN, 1'b0, 0,      1, PROB_ZERO, 0));
        directed.push_back(row(OP_QUERY,   7,       1'b1, 0,      1, PROB_ZERO, 1));
        directed.push_back(row(OP_LOAD,    0,       1'b1, 0,      0, 0,         0));
        directed.push_back(row(OP_LOAD,    20,      1'b0, 500,    0, 0,         0));
        directed.push_back(row(OP_QUERY,   21,      1'b0, 0,      1, PROB_ONE,  0));
        directed.push_back(row(OP_UNKNOWN, VAL_MAX, 1'b1, 131071, 0, 0,         0));
        directed.push_back(row(OP_CLEAR,   0,       1'b0, 0,      0, 0,         0));
        directed.push_back(row(OP_QUERY,   0,       1'b0, 0,      1, PROB_ZERO, 1));
        directed.push_back(row(OP_LOAD,    VAL_MIN, 1'b0, 7,      0, 0,         0));
        directed.push_back(row(OP_LOAD,    VAL_MAX, 1'b0, 65536,  0, 0,         0));
        directed.push_back(row(OP_QUERY,   VAL_MAX, 1'b0, 0,      1, 7,         0));
        directed.push_back(row(OP_QUERY,   0,       1'b0, 0,      0, 0,         0));
        directed.push_back(row(OP_QUERY,   VAL_MIN, 1'b0, 0,      1, PROB_ZERO, 0));
        directed.push_back(row(OP_CLEAR,   VAL_MAX, 1'b1, 131071, 0, 0,         0));
        directed.push_back(row(OP_LOAD,    1,       1'b1, 0,      0, 0,         0));
        directed.push_back(row(OP_QUERY,   1,       1'b0, 0,      1, PROB_ZERO, 1));

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 14;
        recv_idle_pct = 85;
        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].result);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 14 : 0;
            // the full-table pass uses up the item budget of the last phase
            target = items_sent + PHASE_ITEMS;
            if (phase == 2)
            begin
                fill_to_capacity();
                stall_output();
            end
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    run_sorted_session((pick < 5) ? 200 : 30);
                else if (pick < 85)
                    run_broken_session();
                else
                    run_noise($urandom_range(3, 10));
            end
        end

        in_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d items, %0d of them changing the table or asking it, %0d lookups",
                 items_sent, effective_items, results_checked);
        $display("including %0d loads past capacity and %0d long output hold-offs",
                 overflow_loads, holds_done);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: ecdf_left_limit_lookup.f
hw/rtl/ecdf_pkg.sv
hw/rtl/ecdf_ctrl.sv
hw/rtl/ecdf_dp.sv
hw/rtl/ecdf_left_limit_lookup.sv
dv/tb_top.sv
